// ===== rtl/ttlrs_pkg.sv =====
// Shared types, constants and codes for the task table scheduler.
package ttlrs_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PID_W  = 7;
  localparam int RUN_W  = 32;
  localparam int CH_W   = 32;

  localparam logic [CH_W-1:0]  CHILD_TAG = 32'h8000_0000;
  localparam logic [PID_W-1:0] PID_SPILL = PID_W'(SLOTS + 1);

  localparam logic [2:0] RS_OK      = 3'd0;
  localparam logic [2:0] RS_FULL    = 3'd1;
  localparam logic [2:0] RS_IDLE    = 3'd2;
  localparam logic [2:0] RS_BLOCKED = 3'd3;
  localparam logic [2:0] RS_BAD_CH  = 3'd4;

  typedef enum logic [2:0] {
    ACT_SPAWN, ACT_YIELD, ACT_SCHEDULE, ACT_SLEEP, ACT_WAKEUP, ACT_EXIT, ACT_WAIT
  } act_t;

  typedef enum logic [2:0] {
    TS_FREE, TS_NEW, TS_RUNNABLE, TS_RUNNING, TS_WAIT, TS_ZOMBIE
  } task_st_t;

  typedef enum logic [2:0] {
    SC_NONE, SC_SPAWN, SC_SCHED, SC_WAKE, SC_PARENT, SC_REAP
  } scan_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDCUR, S_CAPCUR, S_SPAWN_SCAN, S_PIDSRCH, S_WRNEW, S_SCHED_SCAN,
    S_SCHFIN, S_WAKE_SCAN, S_WRCUR, S_PARENT_SCAN, S_REAP_SCAN, S_REAPWR, S_DONE
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] ppid;
    task_st_t         st;
    logic [RUN_W-1:0] run;
    logic [CH_W-1:0]  wch;
    logic [31:0]      ev;
  } row_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [30:0]        channel;
    logic signed [31:0] exit_value_in;
    logic [6:0]         target_pid;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               switched;
    logic [5:0]         slot_out;
    logic [6:0]         pid_out;
    logic signed [31:0] exit_value_out;
  } result_t;

  typedef struct packed {
    logic  load;
    logic  rd_cur;
    logic  cap_cur;
    scan_t scan;
    logic  pid_step;
    logic  wr_new;
    logic  wr_cur;
    logic  sch_fin;
    logic  reap_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       ch_zero;
    logic       scan_done;
    logic       pid_done;
    logic       par_found;
    logic       reap_found;
  } dp_stat_t;

endpackage

// ===== rtl/ttlrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttlrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ttlrs_ctrl.sv =====
// Controller state machine sequencing the table scans for each event.
module ttlrs_ctrl import ttlrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.scan   = SC_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RDCUR;
        end
      end
      S_RDCUR: begin
        cmd.rd_cur = 1'b1;
        state_next = S_CAPCUR;
      end
      S_CAPCUR: begin
        cmd.cap_cur = 1'b1;
        case (stat.act)
          ACT_SPAWN:                        state_next = S_SPAWN_SCAN;
          ACT_YIELD, ACT_SCHEDULE, ACT_SLEEP: state_next = S_SCHED_SCAN;
          ACT_WAKEUP: state_next = stat.ch_zero ? S_DONE : S_WAKE_SCAN;
          ACT_EXIT:                         state_next = S_WRCUR;
          ACT_WAIT:                         state_next = S_REAP_SCAN;
          default:                          state_next = S_DONE;
        endcase
      end
      S_SPAWN_SCAN: begin
        cmd.scan = SC_SPAWN;
        if (stat.scan_done) begin
          state_next = S_PIDSRCH;
        end
      end
      S_PIDSRCH: begin
        cmd.pid_step = 1'b1;
        if (stat.pid_done) begin
          state_next = S_WRNEW;
        end
      end
      S_WRNEW: begin
        cmd.wr_new = 1'b1;
        state_next = S_DONE;
      end
      S_SCHED_SCAN: begin
        cmd.scan = SC_SCHED;
        if (stat.scan_done) begin
          state_next = S_SCHFIN;
        end
      end
      S_SCHFIN: begin
        cmd.sch_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_WAKE_SCAN: begin
        cmd.scan = SC_WAKE;
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_WRCUR: begin
        cmd.wr_cur = 1'b1;
        state_next = S_PARENT_SCAN;
      end
      S_PARENT_SCAN: begin
        cmd.scan = SC_PARENT;
        if (stat.scan_done) begin
          state_next = stat.par_found ? S_WAKE_SCAN : S_DONE;
        end
      end
      S_REAP_SCAN: begin
        cmd.scan = SC_REAP;
        if (stat.scan_done) begin
          state_next = stat.reap_found ? S_REAPWR : S_SCHED_SCAN;
        end
      end
      S_REAPWR: begin
        cmd.reap_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== rtl/ttlrs_dp.sv =====
// Datapath: task table memory, scan pipeline, selection registers and result.
module ttlrs_dp import ttlrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output result_t  result
);

  localparam int ROW_W = $bits(row_t);

  item_t               itm;
  logic [SLOT_W-1:0]   cur;
  row_t                cur_row;
  logic [SLOTS-1:0]    row_valid;
  logic                rv_q;
  logic [SLOT_W-1:0]   raddr_q;
  logic                pv;
  logic [CNT_W-1:0]    icnt;
  logic [SLOTS:0]      used;
  logic [CNT_W-1:0]    npc;
  logic [PID_W-1:0]    np;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic                best_found;
  logic [SLOT_W-1:0]   best_slot;
  row_t                best_row;
  logic                par_found;
  logic [SLOT_W-1:0]   par_slot;
  logic                reap_found;
  logic [SLOT_W-1:0]   reap_slot;
  row_t                reap_row;

  logic                issue;
  logic [SLOT_W-1:0]   raddr;
  logic [ROW_W-1:0]    rdata;
  row_t                row_q;
  logic                scan_last;
  logic [CH_W-1:0]     wake_ch;
  row_t                m;
  row_t                w;
  logic                eligible;
  logic                better;
  logic                we;
  logic [SLOT_W-1:0]   waddr;
  row_t                wdata;

  ttlrs_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign issue = (cmd.scan != SC_NONE) && (icnt < CNT_W'(SLOTS));
  assign raddr = cmd.rd_cur ? cur : icnt[SLOT_W-1:0];
  assign scan_last = pv && (raddr_q == SLOT_W'(SLOTS - 1));
  assign wake_ch = (itm.action == ACT_EXIT) ? (CHILD_TAG | CH_W'(par_slot))
                                           : {1'b0, itm.channel};

  // A row that was never written holds its reset contents.
  always_comb begin
    if (rv_q) begin
      row_q = row_t'(rdata);
    end else begin
      row_q = '0;
      if (raddr_q == '0) begin
        row_q.pid = PID_W'(1);
        row_q.st  = TS_RUNNABLE;
      end
    end
  end

  always_comb begin
    m = row_q;
    if (raddr_q == cur) begin
      case (itm.action)
        ACT_YIELD: m.st = TS_RUNNABLE;
        ACT_SLEEP: begin
          m.wch = {1'b0, itm.channel};
          m.st  = TS_WAIT;
        end
        ACT_WAIT: begin
          m.wch = CHILD_TAG | CH_W'(cur);
          m.st  = TS_WAIT;
        end
        default: m.st = row_q.st;
      endcase
    end
    if (m.st != TS_FREE && m.st != TS_ZOMBIE && m.st != TS_WAIT) begin
      m.st = TS_RUNNABLE;
    end
    eligible = (m.st == TS_RUNNABLE) && (raddr_q != cur);
    better   = !best_found || (m.run <= best_row.run);
  end

  always_comb begin
    w = row_q;
    if (row_q.st == TS_WAIT && row_q.wch == wake_ch) begin
      w.wch = '0;
      w.st  = TS_RUNNABLE;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = raddr_q;
    wdata = row_q;
    if (cmd.scan == SC_SCHED && pv) begin
      we    = 1'b1;
      wdata = m;
    end else if (cmd.scan == SC_WAKE && pv) begin
      we    = 1'b1;
      wdata = w;
    end else if (cmd.wr_cur) begin
      we        = 1'b1;
      waddr     = cur;
      wdata     = cur_row;
      wdata.wch = '0;
      wdata.st  = TS_ZOMBIE;
      wdata.ev  = itm.exit_value_in;
    end else if (cmd.wr_new && free_found) begin
      we         = 1'b1;
      waddr      = free_slot;
      wdata      = '0;
      wdata.pid  = np;
      wdata.ppid = cur_row.pid;
      wdata.st   = TS_NEW;
    end else if (cmd.sch_fin && best_found) begin
      we       = 1'b1;
      waddr    = best_slot;
      wdata    = best_row;
      wdata.st = TS_RUNNING;
      if (best_row.run != '1) begin
        wdata.run = best_row.run + RUN_W'(1);
      end
    end else if (cmd.reap_wr) begin
      we    = 1'b1;
      waddr = reap_slot;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    rv_q    <= row_valid[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv         <= 1'b0;
      icnt       <= '0;
      row_valid  <= '0;
      cur        <= '0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      par_found  <= 1'b0;
      reap_found <= 1'b0;
    end else begin
      pv <= issue;
      if (stat.scan_done) begin
        icnt <= '0;
      end else if (issue) begin
        icnt <= icnt + CNT_W'(1);
      end
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.sch_fin && best_found) begin
        cur <= best_slot;
      end
      if (cmd.load) begin
        free_found <= 1'b0;
        best_found <= 1'b0;
        par_found  <= 1'b0;
        reap_found <= 1'b0;
      end
      if (cmd.scan == SC_SPAWN && pv && row_q.st == TS_FREE && !free_found) begin
        free_found <= 1'b1;
      end
      if (cmd.scan == SC_SCHED && pv && eligible && better) begin
        best_found <= 1'b1;
      end
      if (cmd.scan == SC_PARENT && pv && !par_found && row_q.st != TS_FREE &&
          row_q.pid == cur_row.ppid) begin
        par_found <= 1'b1;
      end
      if (cmd.scan == SC_REAP && pv && !reap_found && row_q.st == TS_ZOMBIE &&
          raddr_q != cur && row_q.ppid == cur_row.pid &&
          (itm.target_pid == '0 || row_q.pid == itm.target_pid)) begin
        reap_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm  <= item;
      used <= '0;
      npc  <= CNT_W'(1);
    end
    if (cmd.cap_cur) begin
      cur_row <= row_q;
    end
    if (cmd.scan == SC_SPAWN && pv) begin
      if (row_q.st == TS_FREE && !free_found) begin
        free_slot <= raddr_q;
      end
      if (row_q.st != TS_FREE && row_q.pid != '0 &&
          CNT_W'(row_q.pid) <= CNT_W'(SLOTS)) begin
        used[CNT_W'(row_q.pid)] <= 1'b1;
      end
    end
    if (cmd.scan == SC_SCHED && pv) begin
      if (raddr_q == cur) begin
        cur_row <= m;
      end
      if (eligible && better) begin
        best_slot <= raddr_q;
        best_row  <= m;
      end
    end
    if (cmd.scan == SC_PARENT && pv && !par_found && row_q.st != TS_FREE &&
        row_q.pid == cur_row.ppid) begin
      par_slot <= raddr_q;
    end
    if (cmd.scan == SC_REAP && pv && !reap_found && row_q.st == TS_ZOMBIE &&
        raddr_q != cur && row_q.ppid == cur_row.pid &&
        (itm.target_pid == '0 || row_q.pid == itm.target_pid)) begin
      reap_slot <= raddr_q;
      reap_row  <= row_q;
    end
    if (cmd.pid_step) begin
      if (!used[npc]) begin
        np <= PID_W'(npc);
      end else if (npc == CNT_W'(SLOTS)) begin
        np <= PID_SPILL;
      end else begin
        npc <= npc + CNT_W'(1);
      end
    end
  end

  always_comb begin
    stat.act        = itm.action;
    stat.ch_zero    = (itm.channel == '0);
    stat.scan_done  = (cmd.scan != SC_NONE) && scan_last;
    stat.pid_done   = cmd.pid_step && (!used[npc] || npc == CNT_W'(SLOTS));
    stat.par_found  = par_found;
    stat.reap_found = reap_found;
  end

  always_comb begin
    result = '0;
    case (itm.action)
      ACT_SPAWN: begin
        if (free_found) begin
          result.status   = RS_OK;
          result.slot_out = 6'(free_slot);
          result.pid_out  = np;
        end else begin
          result.status = RS_FULL;
        end
      end
      ACT_YIELD, ACT_SCHEDULE, ACT_SLEEP: begin
        if (best_found) begin
          result.status   = RS_OK;
          result.switched = 1'b1;
          result.slot_out = 6'(best_slot);
          result.pid_out  = best_row.pid;
        end else begin
          result.status   = RS_IDLE;
          result.slot_out = 6'(cur);
          result.pid_out  = cur_row.pid;
        end
      end
      ACT_WAKEUP: begin
        result.status = (itm.channel == '0) ? RS_BAD_CH : RS_OK;
      end
      ACT_EXIT: begin
        result.slot_out = 6'(cur);
        result.pid_out  = cur_row.pid;
      end
      ACT_WAIT: begin
        if (reap_found) begin
          result.slot_out       = 6'(reap_slot);
          result.pid_out        = reap_row.pid;
          result.exit_value_out = reap_row.ev;
        end else begin
          result.status   = RS_BLOCKED;
          result.switched = best_found;
          result.slot_out = best_found ? 6'(best_slot) : 6'(cur);
          result.pid_out  = best_found ? best_row.pid : cur_row.pid;
        end
      end
      default: result = '0;
    endcase
  end

endmodule

// ===== rtl/task_table_least_run_scheduler.sv =====
// Top level of the task table with least-run-count scheduler.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------
//   command  | start / busy         | item (item_t)
//   result   | done (one-cycle)     | result (result_t)
//
// An event takes one pass over the table memory per scan, one slot a cycle
// through its single read port; a wait that blocks and an exit with a parent
// each take two passes. Spawn adds a pid search over the pid bitmap.
// Reset is synchronous; the table reads as its reset contents at once.
// The result is shown for one cycle while done is high; it cannot be held off.
module task_table_least_run_scheduler import ttlrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ttlrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ttlrs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule
